### rtl/core/lmq_pkg.sv
// Shared types and constants for the Lamport mutex queue block.
// Used by lmq_cell, lmq_queue and lamport_mutex_queue. No dependencies.
package lmq_pkg;

  localparam int unsigned PID_W  = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ENTRY_W = TIME_W + PID_W;
  localparam int unsigned REENTRY_W = 24;
  localparam logic [REENTRY_W-1:0] REENTRY_MAX = 24'hFF_FFFF;

  typedef enum logic [2:0] {
    CMD_PEER_REQUEST = 3'd0,
    CMD_PEER_RELEASE = 3'd1,
    CMD_PEER_REPLY   = 3'd2,
    CMD_ALL_ACKED    = 3'd3,
    CMD_ACQUIRE      = 3'd4,
    CMD_RELEASE      = 3'd5,
    CMD_ABORT        = 3'd6,
    CMD_PEER_REMOVED = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_GRANTED     = 3'd1,
    ST_BCAST_REQ   = 3'd2,
    ST_BCAST_REL   = 3'd3,
    ST_WAITING     = 3'd4,
    ST_NOT_HOLDING = 3'd5,
    ST_OVERFLOW    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    QOP_HOLD   = 2'd0,
    QOP_INSERT = 2'd1,
    QOP_REMOVE = 2'd2
  } qop_t;

  // Entry: time in the high half, pid in the low half.
  typedef struct packed {
    qop_t               op;
    logic [ENTRY_W-1:0] key;
  } qctl_t;

endpackage

### rtl/core/lamport_mutex_queue.sv
// Lamport distributed mutual exclusion, local node.
// The result strobe is registered from the finish state, which follows the execute state.
// A new command can be taken in the finish (wake-check) state, overlapping it; busy is
// high only in the execute state. All queue slots update in the execute cycle.
// Reset clears clock, count and flags; queue slots hold stale data until written.
// Depends on lmq_pkg and lmq_queue.
module lamport_mutex_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  lmq_pkg::cmd_t                in_cmd,
  input  logic [lmq_pkg::PID_W-1:0]    in_peer_pid,
  input  logic [lmq_pkg::TIME_W-1:0]   in_peer_time,
  output logic                         out_valid,
  output lmq_pkg::status_t             out_status,
  output logic [lmq_pkg::TIME_W-1:0]   out_time_out,
  output logic                         out_woken,
  output logic                         out_holding,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lmq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [PID_W-1:0]    pid_r, pid_nxt;
  logic [TIME_W-1:0]   ptime_r, ptime_nxt;
  logic [PID_W-1:0]    own_pid_r, own_pid_nxt;
  logic [TIME_W-1:0]   clock_r, clock_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                pend_r, pend_nxt;
  logic                ack_r, ack_nxt;
  logic [REENTRY_W-1:0] reent_r, reent_nxt;
  status_t             status_r, status_nxt;
  logic                wake_r, wake_nxt;
  logic                ov_r, ov_nxt;
  status_t             ostat_r, ostat_nxt;
  logic [TIME_W-1:0]   otime_r, otime_nxt;
  logic                owoken_r, owoken_nxt;
  logic                ohold_r, ohold_nxt;

  qctl_t               qctl;
  logic [ENTRY_W-1:0]  head;
  logic                head_hit;
  logic                found;
  logic                holding;
  logic                full;
  logic                accept;
  logic                wake;
  logic                cfg_wr;
  logic [TIME_W-1:0]   merged;

  lmq_queue #(
    .DEPTH (QUEUE_DEPTH),
    .CW    (CW)
  ) u_queue (
    .clk      (clk),
    .ctl      (qctl),
    .count    (count_r),
    .head     (head),
    .head_hit (head_hit),
    .found    (found)
  );

  assign busy    = (state_r == S_EXEC);
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && !paddr[2];
  assign prdata  = paddr[2] ? 32'd0 : own_pid_r;
  assign holding = ack_r && (count_r != '0) && (head[PID_W-1:0] == own_pid_r);
  assign full    = (count_r == FULL);
  assign merged  = ((ptime_r > clock_r) ? ptime_r : clock_r) + TIME_W'(1);
  assign wake    = (state_r == S_FIN) && wake_r && pend_r && holding;

  assign out_valid    = ov_r;
  assign out_status   = ostat_r;
  assign out_time_out = otime_r;
  assign out_woken    = owoken_r;
  assign out_holding  = ohold_r;

  // Queue control for the execute cycle; depends on registers only.
  always_comb begin
    qctl.op  = QOP_HOLD;
    qctl.key = {ptime_r, pid_r};
    if (state_r == S_EXEC) begin
      case (cmd_r)
        CMD_PEER_REQUEST: begin
          if (!full) begin
            qctl.op = QOP_INSERT;
          end
        end
        CMD_PEER_RELEASE: begin
          qctl.op = QOP_REMOVE;
        end
        CMD_ACQUIRE: begin
          if (!holding && !pend_r) begin
            qctl.key = {clock_r + TIME_W'(1), own_pid_r};
            if (!full) begin
              qctl.op = QOP_INSERT;
            end
          end
        end
        CMD_RELEASE: begin
          if (holding && !(reent_r > REENTRY_W'(1))) begin
            qctl.op  = QOP_REMOVE;
            qctl.key = {ptime_r, own_pid_r};
          end
        end
        CMD_ABORT: begin
          qctl.op  = QOP_REMOVE;
          qctl.key = {ptime_r, own_pid_r};
        end
        CMD_PEER_REMOVED: begin
          if (pid_r != own_pid_r) begin
            qctl.op = QOP_REMOVE;
          end
        end
        default: begin
          qctl.op = QOP_HOLD;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    pid_nxt     = pid_r;
    ptime_nxt   = ptime_r;
    own_pid_nxt = cfg_wr ? pwdata : own_pid_r;
    clock_nxt   = clock_r;
    count_nxt   = count_r;
    pend_nxt    = pend_r;
    ack_nxt     = ack_r;
    reent_nxt   = reent_r;
    status_nxt  = status_r;
    wake_nxt    = wake_r;
    ov_nxt      = 1'b0;
    ostat_nxt   = ostat_r;
    otime_nxt   = otime_r;
    owoken_nxt  = owoken_r;
    ohold_nxt   = ohold_r;

    if (accept) begin
      cmd_nxt   = in_cmd;
      pid_nxt   = in_peer_pid;
      ptime_nxt = in_peer_time;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_FIN;
        status_nxt = ST_DONE;
        wake_nxt   = 1'b0;
        case (cmd_r)
          CMD_PEER_REQUEST: begin
            clock_nxt = merged;
            if (full) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_PEER_RELEASE: begin
            clock_nxt = merged;
            if (found) begin
              count_nxt = count_r - CW'(1);
            end
            wake_nxt = head_hit;
          end
          CMD_PEER_REPLY: begin
            clock_nxt = merged;
          end
          CMD_ALL_ACKED: begin
            ack_nxt  = 1'b1;
            wake_nxt = 1'b1;
          end
          CMD_ACQUIRE: begin
            if (holding) begin
              if (reent_r >= REENTRY_MAX) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                reent_nxt  = reent_r + REENTRY_W'(1);
                status_nxt = ST_GRANTED;
              end
            end else if (pend_r) begin
              status_nxt = ST_WAITING;
            end else begin
              clock_nxt = clock_r + TIME_W'(1);
              if (full) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                count_nxt  = count_r + CW'(1);
                pend_nxt   = 1'b1;
                status_nxt = ST_BCAST_REQ;
              end
            end
          end
          CMD_RELEASE: begin
            if (!holding) begin
              status_nxt = ST_NOT_HOLDING;
            end else if (reent_r > REENTRY_W'(1)) begin
              reent_nxt = reent_r - REENTRY_W'(1);
            end else begin
              reent_nxt  = '0;
              clock_nxt  = clock_r + TIME_W'(1);
              ack_nxt    = 1'b0;
              if (found) begin
                count_nxt = count_r - CW'(1);
              end
              status_nxt = ST_BCAST_REL;
            end
          end
          CMD_ABORT: begin
            pend_nxt   = 1'b0;
            clock_nxt  = clock_r + TIME_W'(1);
            ack_nxt    = 1'b0;
            if (found) begin
              count_nxt = count_r - CW'(1);
            end
            status_nxt = ST_BCAST_REL;
          end
          default: begin
            // peer removed: own pid is never dropped this way
            if (pid_r != own_pid_r) begin
              if (found) begin
                count_nxt = count_r - CW'(1);
              end
              wake_nxt = head_hit;
            end
          end
        endcase
      end
      S_FIN: begin
        state_nxt = accept ? S_EXEC : S_IDLE;
        if (wake) begin
          pend_nxt  = 1'b0;
          clock_nxt = clock_r + TIME_W'(1);
          if (reent_r < REENTRY_MAX) begin
            reent_nxt = reent_r + REENTRY_W'(1);
          end
        end
        ov_nxt     = 1'b1;
        ostat_nxt  = (cmd_r == CMD_ALL_ACKED) ? (wake ? ST_GRANTED : ST_DONE) : status_r;
        otime_nxt  = clock_r + TIME_W'(wake);
        owoken_nxt = wake;
        ohold_nxt  = holding;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      own_pid_r <= '0;
      clock_r   <= '0;
      count_r   <= '0;
      pend_r    <= 1'b0;
      ack_r     <= 1'b0;
      reent_r   <= '0;
      wake_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      own_pid_r <= own_pid_nxt;
      clock_r   <= clock_nxt;
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      ack_r     <= ack_nxt;
      reent_r   <= reent_nxt;
      wake_r    <= wake_nxt;
      ov_r      <= ov_nxt;
    end
    cmd_r    <= cmd_nxt;
    pid_r    <= pid_nxt;
    ptime_r  <= ptime_nxt;
    status_r <= status_nxt;
    ostat_r  <= ostat_nxt;
    otime_r  <= otime_nxt;
    owoken_r <= owoken_nxt;
    ohold_r  <= ohold_nxt;
  end

endmodule

### rtl/core/lmq_cell.sv
// One slot of the sorted request queue.
// Depends on lmq_pkg. Inserts shift toward the tail, removals toward the head.
module lmq_cell (
  input  logic                        clk,
  input  lmq_pkg::qctl_t              ctl,
  input  logic                        occ,
  input  logic                        prev_le,
  input  logic [lmq_pkg::ENTRY_W-1:0] prev_entry,
  input  logic [lmq_pkg::ENTRY_W-1:0] next_entry,
  input  logic                        hit_in,
  output logic [lmq_pkg::ENTRY_W-1:0] entry,
  output logic                        le,
  output logic                        hit
);
  import lmq_pkg::*;

  logic [ENTRY_W-1:0] entry_r;
  logic [ENTRY_W-1:0] entry_nxt;
  logic               match;

  assign entry = entry_r;
  assign le    = occ && (entry_r <= ctl.key);
  assign match = occ && (entry_r[PID_W-1:0] == ctl.key[PID_W-1:0]);
  assign hit   = hit_in || match;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      QOP_INSERT: begin
        // keep if not above the new key, else take the new key at the boundary or shift in the previous entry
        if (!le) begin
          entry_nxt = prev_le ? ctl.key : prev_entry;
        end
      end
      QOP_REMOVE: begin
        if (hit) begin
          entry_nxt = next_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### rtl/core/lmq_queue.sv
// Chain of lmq_cell slots forming the sorted request queue.
// Depends on lmq_pkg and lmq_cell.
module lmq_queue #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  lmq_pkg::qctl_t              ctl,
  input  logic [CW-1:0]               count,
  output logic [lmq_pkg::ENTRY_W-1:0] head,
  output logic                        head_hit,
  output logic                        found
);
  import lmq_pkg::*;

  logic [ENTRY_W-1:0] entries [DEPTH];
  logic [DEPTH-1:0]   le_v;
  logic [DEPTH-1:0]   hit_v;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               occ;
    logic               p_le;
    logic               p_hit;
    logic [ENTRY_W-1:0] p_entry;
    logic [ENTRY_W-1:0] n_entry;

    assign occ = count > CW'(i);

    if (i == 0) begin : g_first
      assign p_le    = 1'b1;
      assign p_hit   = 1'b0;
      assign p_entry = ctl.key;
    end else begin : g_rest
      assign p_le    = le_v[i-1];
      assign p_hit   = hit_v[i-1];
      assign p_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_entry = entries[i];
    end else begin : g_mid
      assign n_entry = entries[i+1];
    end

    lmq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .prev_le    (p_le),
      .prev_entry (p_entry),
      .next_entry (n_entry),
      .hit_in     (p_hit),
      .entry      (entries[i]),
      .le         (le_v[i]),
      .hit        (hit_v[i])
    );
  end

  assign head     = entries[0];
  assign head_hit = hit_v[0];
  assign found    = hit_v[DEPTH-1];

endmodule

### sim/tb_lamport_mutex_queue.sv
// Self-checking testbench for lamport_mutex_queue: directed table, then random lock traffic.
// Models the lock node and checks each result beat against it or a typed table row.
// Depends on lmq_pkg and the lamport_mutex_queue RTL.
`timescale 1ns / 1ps

module tb_lamport_mutex_queue;
  import lmq_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic [2:0] ADDR_OWN_PID = 3'd0;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 210;

  typedef struct packed {
    status_t     status;
    logic [31:0] tstamp;
    logic        woken;
    logic        holding;
  } lock_result_t;

  typedef struct packed {
    cmd_t        c;
    logic [31:0] pid;
    logic [31:0] ptime;
    logic        typed;
    status_t     st;
    logic [31:0] ts;
    logic        wk;
    logic        hd;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  cmd_t in_cmd;
  logic [31:0] in_peer_pid;
  logic [31:0] in_peer_time;
  logic out_valid;
  status_t out_status;
  logic [31:0] out_time_out;
  logic out_woken;
  logic out_holding;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lamport_mutex_queue #(.QUEUE_DEPTH(QDEPTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_peer_pid(in_peer_pid), .in_peer_time(in_peer_time),
    .out_valid(out_valid), .out_status(out_status), .out_time_out(out_time_out),
    .out_woken(out_woken), .out_holding(out_holding),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lock node state as this testbench tracks it
  logic [31:0] node_pid = '0;
  logic [31:0] node_clock = '0;
  logic [63:0] req_q [QDEPTH];
  int          req_count = 0;
  logic        pending = 1'b0;
  logic        acked = 1'b0;
  logic [23:0] reentry = '0;

  lock_result_t lock_results_q [$];
  int err_count = 0;
  int cmds_sent = 0;
  int results_seen = 0;
  int status_seen [8];
  int wakes_seen = 0;

  dir_row_t dir_tbl [0:22] = '{
    '{CMD_RELEASE,      32'h0,        32'h0,        1'b1, ST_NOT_HOLDING, 32'h0, 1'b0, 1'b0},
    '{CMD_PEER_REPLY,   32'h5,        32'hFFFFFFFF, 1'b1, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_PEER_REPLY,   32'h5,        32'h0,        1'b1, ST_DONE,      32'h1, 1'b0, 1'b0},
    '{CMD_ACQUIRE,      32'h0,        32'h0,        1'b1, ST_BCAST_REQ, 32'h2, 1'b0, 1'b0},
    '{CMD_ACQUIRE,      32'h0,        32'h0,        1'b1, ST_WAITING,   32'h2, 1'b0, 1'b0},
    '{CMD_ALL_ACKED,    32'h0,        32'h0,        1'b1, ST_GRANTED,   32'h3, 1'b1, 1'b1},
    '{CMD_ACQUIRE,      32'h0,        32'h0,        1'b1, ST_GRANTED,   32'h3, 1'b0, 1'b1},
    '{CMD_RELEASE,      32'h0,        32'h0,        1'b1, ST_DONE,      32'h3, 1'b0, 1'b1},
    '{CMD_PEER_REQUEST, 32'h7,        32'h1,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_RELEASE,      32'h0,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_PEER_REMOVED, 32'h0,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_PEER_RELEASE, 32'h7,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_RELEASE,      32'h0,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_PEER_REQUEST, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_PEER_REQUEST, 32'h3,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_ACQUIRE,      32'h0,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_ALL_ACKED,    32'h0,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_PEER_REMOVED, 32'h3,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_ABORT,        32'h0,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_PEER_RELEASE, 32'h12345678, 32'h2,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_ABORT,        32'h0,        32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0},
    '{CMD_PEER_REPLY,   32'hFFFFFFFF, 32'h7FFFFFFF, 1'b1, ST_DONE, 32'h80000000, 1'b0, 1'b0},
    '{CMD_PEER_REMOVED, 32'hFFFFFFFF, 32'h0,        1'b0, ST_DONE,      32'h0, 1'b0, 1'b0}
  };

  logic [31:0] peer_pool [4];

  function automatic void merge_clock(logic [31:0] t);
    node_clock = ((t > node_clock) ? t : node_clock) + 32'd1;
  endfunction

  function automatic logic node_holding();
    return acked && req_count > 0 && req_q[0][31:0] == node_pid;
  endfunction

  function automatic int find_pid(logic [31:0] pid);
    for (int i = 0; i < req_count; i++)
      if (req_q[i][31:0] == pid) return i;
    return req_count;
  endfunction

  function automatic void erase_entry(int i);
    if (i >= req_count) return;
    for (int k = i; k + 1 < req_count; k++) req_q[k] = req_q[k+1];
    req_count--;
  endfunction

  // Place the entry after every entry that is less than or equal to it.
  function automatic logic insert_entry(logic [31:0] t, logic [31:0] pid);
    logic [63:0] e;
    int i;
    e = {t, pid};
    if (req_count >= QDEPTH) return 1'b0;
    i = 0;
    while (i < req_count && req_q[i] <= e) i++;
    for (int k = req_count; k > i; k--) req_q[k] = req_q[k-1];
    req_q[i] = e;
    req_count++;
    return 1'b1;
  endfunction

  function automatic logic try_wake();
    if (!pending || !node_holding()) return 1'b0;
    pending = 1'b0;
    node_clock = node_clock + 32'd1;
    if (reentry < REENTRY_MAX) reentry = reentry + 24'd1;
    return 1'b1;
  endfunction

  function automatic void drop_own();
    node_clock = node_clock + 32'd1;
    acked = 1'b0;
    erase_entry(find_pid(node_pid));
  endfunction

  function automatic void remove_peer(logic [31:0] pid, inout logic woke);
    int j;
    j = find_pid(pid);
    if (j < req_count) begin
      erase_entry(j);
      if (j == 0) woke = try_wake();
    end
  endfunction

  function automatic lock_result_t lock_predict(cmd_t c, logic [31:0] pid, logic [31:0] t);
    lock_result_t r;
    logic woke;
    r.status = ST_DONE;
    woke = 1'b0;
    case (c)
      CMD_PEER_REQUEST: begin
        merge_clock(t);
        if (!insert_entry(t, pid)) r.status = ST_OVERFLOW;
      end
      CMD_PEER_RELEASE: begin
        merge_clock(t);
        remove_peer(pid, woke);
      end
      CMD_PEER_REPLY: merge_clock(t);
      CMD_ALL_ACKED: begin
        acked = 1'b1;
        woke = try_wake();
        r.status = woke ? ST_GRANTED : ST_DONE;
      end
      CMD_ACQUIRE: begin
        if (node_holding()) begin
          if (reentry >= REENTRY_MAX) begin
            r.status = ST_OVERFLOW;
          end else begin
            reentry = reentry + 24'd1;
            r.status = ST_GRANTED;
          end
        end else if (pending) begin
          r.status = ST_WAITING;
        end else begin
          node_clock = node_clock + 32'd1;
          if (insert_entry(node_clock, node_pid)) begin
            pending = 1'b1;
            r.status = ST_BCAST_REQ;
          end else begin
            r.status = ST_OVERFLOW;
          end
        end
      end
      CMD_RELEASE: begin
        if (!node_holding()) begin
          r.status = ST_NOT_HOLDING;
        end else if (reentry > 24'd1) begin
          reentry = reentry - 24'd1;
        end else begin
          reentry = '0;
          drop_own();
          r.status = ST_BCAST_REL;
        end
      end
      CMD_ABORT: begin
        pending = 1'b0;
        drop_own();
        r.status = ST_BCAST_REL;
      end
      default: begin
        if (pid != node_pid) remove_peer(pid, woke);
      end
    endcase
    r.tstamp = node_clock;
    r.woken = woke;
    r.holding = node_holding();
    return r;
  endfunction

  // Result beats cannot be held off: check each one as it goes by.
  always @(posedge clk) begin
    lock_result_t e;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      status_seen[out_status]++;
      if (out_woken === 1'b1) wakes_seen++;
      if (lock_results_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result beat status=%0d time=%h woken=%b holding=%b",
                 $time, out_status, out_time_out, out_woken, out_holding);
      end else begin
        e = lock_results_q.pop_front();
        if (out_status !== e.status || out_time_out !== e.tstamp ||
            out_woken !== e.woken || out_holding !== e.holding) begin
          err_count++;
          $display("%0t: mismatch expected status=%0d time=%h woken=%b holding=%b",
                   $time, e.status, e.tstamp, e.woken, e.holding);
          $display("%0t:          actual   status=%0d time=%h woken=%b holding=%b",
                   $time, out_status, out_time_out, out_woken, out_holding);
        end
      end
    end
  end

  // Hold the command until it is taken, then predict its result.
  task automatic issue_cmd(cmd_t c, logic [31:0] pid, logic [31:0] t,
                           logic typed, lock_result_t typed_res);
    lock_result_t r;
    start <= 1'b1;
    in_cmd <= c;
    in_peer_pid <= pid;
    in_peer_time <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = lock_predict(c, pid, t);
    lock_results_q.push_back(typed ? typed_res : r);
    cmds_sent++;
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic send(cmd_t c, logic [31:0] pid, logic [31:0] t, int pct);
    issue_cmd(c, pid, t, 1'b0, '0);
    idle_gap(pct);
  endtask

  // Pause the command side until every result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (lock_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_own_pid(logic [31:0] pid);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_OWN_PID;
    pwdata <= pid;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    node_pid = pid;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== pid) begin
      err_count++;
      $display("%0t: own_pid readback expected %h got %h", $time, pid, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0: return 32'hFFFFFFFF;
      1: return 32'h0;
      2: return $urandom();
      3: return 32'($urandom_range(0, 7));
      default: return node_clock + 32'($urandom_range(0, 4)) - 32'd2;
    endcase
  endfunction

  function automatic logic [31:0] pick_peer();
    if ($urandom_range(0, 19) == 0) return node_pid;
    return peer_pool[$urandom_range(0, 3)];
  endfunction

  // Mostly follow the lock protocol from the node's present state; some noise.
  function automatic void pick_cmd(output cmd_t c, output logic [31:0] pid,
                                   output logic [31:0] t);
    int w;
    w = $urandom_range(0, 99);
    pid = pick_peer();
    t = pick_time();
    if ($urandom_range(0, 99) < 15) begin
      c = cmd_t'($urandom_range(0, 7));
      if ($urandom_range(0, 1)) pid = $urandom();
      return;
    end
    if (node_holding() && w < 50) begin
      c = (w < 32) ? CMD_RELEASE : CMD_ACQUIRE;
      return;
    end
    if (pending && w < 65) begin
      if (w < 30) c = CMD_PEER_REPLY;
      else if (w < 55) c = CMD_ALL_ACKED;
      else if (w < 60) c = CMD_ABORT;
      else c = CMD_ACQUIRE;
      return;
    end
    if (!pending && !node_holding() && w < 30) begin
      c = CMD_ACQUIRE;
      return;
    end
    w = $urandom_range(0, 99);
    if (req_count < 12 && w < 50) begin
      c = CMD_PEER_REQUEST;
    end else if (req_count > 0 && w < 90) begin
      pid = req_q[$urandom_range(0, req_count - 1)][31:0];
      c = ($urandom_range(0, 9) < 7) ? CMD_PEER_RELEASE : CMD_PEER_REMOVED;
    end else begin
      c = CMD_PEER_REPLY;
    end
  endfunction

  // Overfill the queue, try to acquire into it, then drain it from the head.
  task automatic flood_queue(int pct);
    send(CMD_ABORT, 32'h0, 32'h0, pct);
    repeat (QDEPTH + 1) send(CMD_PEER_REQUEST, peer_pool[$urandom_range(0, 3)],
                             pick_time(), pct);
    send(CMD_ACQUIRE, 32'h0, 32'h0, pct);
    while (req_count > 0) begin
      if (req_q[0][31:0] == node_pid) send(CMD_ABORT, 32'h0, 32'h0, pct);
      else send(CMD_PEER_RELEASE, req_q[0][31:0], pick_time(), pct);
    end
  endtask

  initial begin
    logic [31:0] pid_set [PHASES];
    int pct_set [PHASES];
    lock_result_t typed_res;
    cmd_t c;
    logic [31:0] pid;
    logic [31:0] t;
    int pct;
    int guard;

    pid_set = '{32'h0, 32'hFFFFFFFF, 32'h80000000, $urandom(), 32'h1};
    pct_set = '{0, 82, 22, 82, 22};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_PEER_REPLY;
    in_peer_pid <= '0;
    in_peer_time <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table runs with own_pid at its reset value.
    foreach (dir_tbl[i]) begin
      typed_res = '{dir_tbl[i].st, dir_tbl[i].ts, dir_tbl[i].wk, dir_tbl[i].hd};
      issue_cmd(dir_tbl[i].c, dir_tbl[i].pid, dir_tbl[i].ptime, dir_tbl[i].typed, typed_res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_own_pid(pid_set[ph]);
      peer_pool = '{pid_set[ph] ^ 32'h1, pid_set[ph] + 32'd5, $urandom(), $urandom()};
      @(posedge clk);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // alternate stretches with and without sender gaps
        pct = ((n / 40) % 2 == 0) ? pct_set[ph] : 0;
        if (n == ITEMS_PER_PHASE / 2) flood_queue(pct);
        pick_cmd(c, pid, t);
        send(c, pid, t, pct);
      end
    end

    start <= 1'b0;
    guard = 0;
    while (lock_results_q.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (lock_results_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, lock_results_q.size());
    end

    $display("Sent %0d lock commands over %0d own_pid settings; checked %0d results.",
             cmds_sent, PHASES, results_seen);
    $display("Grants %0d, broadcasts %0d/%0d, overflows %0d, wakes %0d.",
             status_seen[ST_GRANTED], status_seen[ST_BCAST_REQ], status_seen[ST_BCAST_REL],
             status_seen[ST_OVERFLOW], wakes_seen);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #3000000;
    $display("%0t: run did not finish in time", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
